[src/tsre_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the text screen region engine.
// No dependencies.
package tsre_pkg;

    // default screen geometry
    localparam int TSRE_ROWS = 25;
    localparam int TSRE_COLS = 80;

    localparam logic [7:0] BLANK_CHAR = 8'h20;

    // reset values of the colour registers
    localparam logic [3:0] FG_RESET = 4'hf;
    localparam logic [2:0] BG_RESET = 3'h1;

    // configuration register indexes
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    typedef enum logic [2:0] {
        FN_PRINT   = 3'd0,
        FN_CLEAR   = 3'd1,
        FN_SCROLL  = 3'd2,
        FN_SAVE    = 3'd3,
        FN_RESTORE = 3'd4,
        FN_READ    = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE     = 2'd0,
        STAT_IGNORED  = 2'd1,
        STAT_PAST_END = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_SHIFT,
        ST_PEEK,
        ST_MODIFY,
        ST_XFER,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [15:0] value;
        logic        last_cell;
    } t_result;

    // walker commands: load a start cell, or advance one cell (wrap to next row)
    typedef struct packed {
        logic load;
        logic step;
        logic wrap;
    } t_walk_ctl;

endpackage

[src/tsre_cell_ram.sv]
`timescale 1ns / 1ps
// Single-port screen cell memory, read-first, registered read data.
// Depends on nothing; sizes come from the parent.
module tsre_cell_ram #(
    parameter int CELLS = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [15:0]   i_wdata,
    output logic [15:0]   o_rdata
);

    logic [15:0] mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

[src/tsre_walker.sv]
`timescale 1ns / 1ps
// Cell walker: row/column position and row base, address and row-below adders.
// Depends on tsre_pkg.
module tsre_walker #(
    parameter int ROWS = 25,
    parameter int COLS = 80,
    parameter int RW   = 5,
    parameter int CW   = 7,
    parameter int AW   = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tsre_pkg::t_walk_ctl   i_ctl,
    input  logic [RW-1:0]         i_ld_row,
    input  logic [CW-1:0]         i_ld_col,
    output logic [RW-1:0]         o_row,
    output logic [CW-1:0]         o_col,
    output logic [AW-1:0]         o_addr,
    output logic [AW-1:0]         o_addr_below
);
    import tsre_pkg::*;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_base <= '0;
        end else if (i_ctl.load) begin
            r_row  <= i_ld_row;
            r_col  <= i_ld_col;
            r_base <= AW'(i_ld_row * COLS);
        end else if (i_ctl.step) begin
            if (i_ctl.wrap) begin
                r_row  <= r_row + RW'(1);
                r_col  <= i_ld_col;
                r_base <= r_base + AW'(COLS);
            end else begin
                r_col  <= r_col + CW'(1);
            end
        end
    end

    // row below is only asked for when it lies on screen
    assign o_addr       = r_base + AW'(r_col);
    assign o_addr_below = o_addr + AW'(COLS);
    assign o_row        = r_row;
    assign o_col        = r_col;

endmodule

[src/tsre_seq.sv]
`timescale 1ns / 1ps
// Command sequencer: decode, clipping, save/restore cursor, per-cell walk.
// Depends on tsre_pkg, tsre_walker and tsre_cell_ram.
module tsre_seq #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic [7:0]         i_top_row,
    input  logic [7:0]         i_left_col,
    input  logic [7:0]         i_bottom_row,
    input  logic [7:0]         i_right_col,
    input  logic [7:0]         i_char_code,
    input  logic [15:0]        i_cell_word,
    input  logic               i_first_cell,
    input  logic [3:0]         i_fg,
    input  logic [2:0]         i_bg,
    output logic               o_res_valid,
    output tsre_pkg::t_result  o_res,
    input  logic               i_res_take
);
    import tsre_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam logic [7:0] ROWS8    = 8'(ROWS);
    localparam logic [7:0] COLS8    = 8'(COLS);
    localparam logic [7:0] ROW_MAX8 = 8'(ROWS - 1);
    localparam logic [7:0] COL_MAX8 = 8'(COLS - 1);

    t_state r_state, n_state;

    // captured item
    logic [2:0]  r_func;
    logic [7:0]  r_top, r_left, r_bottom, r_right, r_char;
    logic [15:0] r_cell_word;
    logic        r_first;

    // region bounds used by the walk
    logic [RW-1:0] r_r1;
    logic [CW-1:0] r_c0, r_c1;

    // save/restore cursor
    logic [RW-1:0] r_cur_row;
    logic [CW-1:0] r_cur_col;
    logic          r_xfer_done;

    t_status     r_status;
    logic [15:0] r_value;
    logic        r_last;

    // decode
    logic [7:0]    r0c, c0c, r1c, c1c;
    logic          nonempty, onscreen, cur_out, dec_go, dec_load;
    logic          dec_done_set, dec_done_clr, dec_last;
    t_status       dec_status;
    logic [RW-1:0] go_row, dec_row;
    logic [CW-1:0] go_col, dec_col;

    // walker / memory
    t_walk_ctl     walk;
    logic [RW-1:0] w_row, ld_row;
    logic [CW-1:0] w_col, ld_col;
    logic [AW-1:0] w_addr, w_addr_below, ram_addr;
    logic          ram_we, sel_below;
    logic [15:0]   ram_wdata, ram_rdata;
    logic          at_last_row, at_row_end, at_last, accept;

    assign accept      = i_in_valid && !o_in_stall;
    assign at_last_row = (w_row == r_r1);
    assign at_row_end  = (w_col == r_c1);
    assign at_last     = at_last_row && at_row_end;

    always_comb begin
        r0c = r_top[7]  ? 8'd0 : r_top;
        c0c = r_left[7] ? 8'd0 : r_left;
        r1c = (!r_bottom[7] && r_bottom > ROW_MAX8) ? ROW_MAX8 : r_bottom;
        c1c = (!r_right[7]  && r_right  > COL_MAX8) ? COL_MAX8 : r_right;
        // a negative end means an empty region
        nonempty = !r1c[7] && !c1c[7] && (r0c <= r1c) && (c0c <= c1c);
        onscreen = !r_top[7] && (r_top < ROWS8) && !r_left[7] && (r_left < COLS8);
        cur_out  = (8'(r_cur_row) < r0c) || (8'(r_cur_row) > r1c) ||
                   (8'(r_cur_col) < c0c) || (8'(r_cur_col) > c1c);

        go_row = r_first ? r0c[RW-1:0] : r_cur_row;
        go_col = r_first ? c0c[CW-1:0] : r_cur_col;

        dec_go       = 1'b0;
        dec_done_set = 1'b0;
        dec_done_clr = 1'b0;
        dec_status   = STAT_IGNORED;
        if (r_first) begin
            if (nonempty) begin
                dec_go       = 1'b1;
                dec_done_clr = 1'b1;
            end else begin
                dec_done_set = 1'b1;
            end
        end else if (r_xfer_done) begin
            dec_status = STAT_PAST_END;
        end else if (!nonempty) begin
            dec_done_set = 1'b1;
        end else if (cur_out) begin
            dec_status   = STAT_PAST_END;
            dec_done_set = 1'b1;
        end else begin
            dec_go = 1'b1;
        end
        if (dec_go) begin
            dec_status = STAT_DONE;
        end
        dec_last = dec_go && (go_col == c1c[CW-1:0]) && (go_row == r1c[RW-1:0]);

        dec_load = 1'b0;
        dec_row  = go_row;
        dec_col  = go_col;
        case (r_func)
            FN_PRINT, FN_READ: begin
                dec_load = onscreen;
                dec_row  = r_top[RW-1:0];
                dec_col  = r_left[CW-1:0];
            end
            FN_CLEAR, FN_SCROLL: begin
                dec_load = nonempty;
                dec_row  = r0c[RW-1:0];
                dec_col  = c0c[CW-1:0];
            end
            FN_SAVE, FN_RESTORE: begin
                dec_load = dec_go;
            end
            default: begin
                dec_load = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (at_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                case (r_func)
                    FN_PRINT, FN_READ:   n_state = onscreen ? ST_PEEK : ST_RESULT;
                    FN_CLEAR, FN_SCROLL: n_state = nonempty ? ST_WALK : ST_RESULT;
                    FN_SAVE:             n_state = dec_go ? ST_PEEK : ST_RESULT;
                    FN_RESTORE:          n_state = dec_go ? ST_XFER : ST_RESULT;
                    default:             n_state = ST_RESULT;
                endcase
            end
            ST_WALK: begin
                if (r_func == FN_SCROLL && !at_last_row) begin
                    n_state = ST_SHIFT;
                end else if (at_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_SHIFT:  n_state = ST_WALK;
            ST_PEEK:   n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_RESULT;
            ST_XFER:   n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_res_take) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        walk        = '0;
        ram_we      = 1'b0;
        ram_wdata   = '0;
        sel_below   = 1'b0;
        ld_row      = dec_row;
        ld_col      = (r_state == ST_DECODE) ? dec_col : r_c0;
        o_in_stall  = (r_state != ST_IDLE);
        o_res_valid = (r_state == ST_RESULT);
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                walk.step = !at_last;
                walk.wrap = at_row_end;
            end
            ST_DECODE: begin
                walk.load = dec_load;
            end
            ST_WALK: begin
                if (r_func == FN_SCROLL && !at_last_row) begin
                    sel_below = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b0, i_bg, i_fg, BLANK_CHAR};
                    walk.step = !at_last;
                    walk.wrap = at_row_end;
                end
            end
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                walk.step = 1'b1;
                walk.wrap = at_row_end;
            end
            ST_MODIFY: begin
                // print keeps the old background nibble
                ram_we    = (r_func == FN_PRINT);
                ram_wdata = {ram_rdata[15:12], i_fg, r_char};
            end
            ST_XFER: begin
                ram_we    = 1'b1;
                ram_wdata = r_cell_word;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign ram_addr = sel_below ? w_addr_below : w_addr;
    assign o_res    = '{status: r_status, value: r_value, last_cell: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r1        <= RW'(ROWS - 1);
            r_c0        <= '0;
            r_c1        <= CW'(COLS - 1);
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_xfer_done <= 1'b1;
        end else if (r_state == ST_DECODE) begin
            if ((r_func == FN_CLEAR || r_func == FN_SCROLL) && nonempty) begin
                r_r1 <= r1c[RW-1:0];
                r_c0 <= c0c[CW-1:0];
                r_c1 <= c1c[CW-1:0];
            end
            if (r_func == FN_SAVE || r_func == FN_RESTORE) begin
                if (dec_done_set || dec_last) begin
                    r_xfer_done <= 1'b1;
                end else if (dec_done_clr) begin
                    r_xfer_done <= 1'b0;
                end
                if (dec_go) begin
                    if (go_col == c1c[CW-1:0]) begin
                        r_cur_col <= c0c[CW-1:0];
                        r_cur_row <= go_row + RW'(1);
                    end else begin
                        r_cur_col <= go_col + CW'(1);
                        r_cur_row <= go_row;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_func      <= i_func;
            r_top       <= i_top_row;
            r_left      <= i_left_col;
            r_bottom    <= i_bottom_row;
            r_right     <= i_right_col;
            r_char      <= i_char_code;
            r_cell_word <= i_cell_word;
            r_first     <= i_first_cell;
        end
        if (r_state == ST_DECODE) begin
            case (r_func)
                FN_PRINT, FN_READ:   r_status <= onscreen ? STAT_DONE : STAT_IGNORED;
                FN_CLEAR, FN_SCROLL: r_status <= nonempty ? STAT_DONE : STAT_IGNORED;
                FN_SAVE, FN_RESTORE: r_status <= dec_status;
                default:             r_status <= STAT_IGNORED;
            endcase
            r_value <= '0;
            r_last  <= (r_func == FN_SAVE || r_func == FN_RESTORE) && dec_last;
        end
        if (r_state == ST_MODIFY && r_func != FN_PRINT) begin
            r_value <= ram_rdata;
        end
    end

    tsre_walker #(
        .ROWS (ROWS),
        .COLS (COLS),
        .RW   (RW),
        .CW   (CW),
        .AW   (AW)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (walk),
        .i_ld_row     (ld_row),
        .i_ld_col     (ld_col),
        .o_row        (w_row),
        .o_col        (w_col),
        .o_addr       (w_addr),
        .o_addr_below (w_addr_below)
    );

    tsre_cell_ram #(
        .CELLS (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    a_we_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_addr} < (AW+1)'(CELLS)))
        else $error("cell write beyond screen");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != STAT_DONE) |-> (o_res.value == 16'd0 && !o_res.last_cell))
        else $error("failed command carries data");

    a_take_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_take |=> (r_state == ST_IDLE))
        else $error("sequencer not idle after result taken");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_cell) |-> r_xfer_done)
        else $error("final cell left transfer open");

endmodule

[src/text_screen_region_engine.sv]
`timescale 1ns / 1ps
// Top level: colour registers, result output register, command sequencer.
// Depends on tsre_pkg and tsre_seq.
//
//  channel  direction  handshake               payload
//  in       to block   i_in_valid / o_in_stall  func, bounds, char, cell word, first
//  out      from block o_out_valid / i_out_stall status, cell value, last cell
//  cfg      to block   i_cfg_valid / o_cfg_ready index, data
//
// Acting print, read and save go through decode, peek and modify, restore
// through decode and transfer. Clear writes each cell of the clipped region
// in turn; scroll copies the cell below into each cell above the bottom row
// and blanks the bottom row, all through the single memory port. One item is
// in work at a time. After reset a clearing pass writes every cell with the
// input stalled. The result register lets an item start while a word waits.
module text_screen_region_engine #(
    parameter int ROWS = tsre_pkg::TSRE_ROWS,
    parameter int COLS = tsre_pkg::TSRE_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_top_row,
    input  logic [7:0]  i_left_col,
    input  logic [7:0]  i_bottom_row,
    input  logic [7:0]  i_right_col,
    input  logic [7:0]  i_char_code,
    input  logic [15:0] i_cell_word,
    input  logic        i_first_cell,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_cell_value,
    output logic        o_last_cell,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import tsre_pkg::*;

    logic [3:0] r_fg;
    logic [2:0] r_bg;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       res_valid, res_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= FG_RESET;
            r_bg <= BG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FG:  r_fg <= i_cfg_data;
                CFG_BG:  r_bg <= i_cfg_data[2:0];
                default: r_fg <= r_fg;
            endcase
        end
    end

    // result moves on when the register is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_cell_value = r_out.value;
    assign o_last_cell  = r_out.last_cell;

    tsre_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_top_row    (i_top_row),
        .i_left_col   (i_left_col),
        .i_bottom_row (i_bottom_row),
        .i_right_col  (i_right_col),
        .i_char_code  (i_char_code),
        .i_cell_word  (i_cell_word),
        .i_first_cell (i_first_cell),
        .i_fg         (r_fg),
        .i_bg         (r_bg),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (res_take)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for text_screen_region_engine: a screen tracker class
// predicts every result word, plain tasks drive the command and colour ports.
// Depends on tsre_pkg and the engine RTL.
module tb;
    import tsre_pkg::*;

    localparam int ROWS          = TSRE_ROWS;
    localparam int COLS          = TSRE_COLS;
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;

    // func codes the block leaves unused
    localparam logic [2:0] FN_SPARE_A = 3'd6;
    localparam logic [2:0] FN_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  top_row;
        logic [7:0]  left_col;
        logic [7:0]  bottom_row;
        logic [7:0]  right_col;
        logic [7:0]  char_code;
        logic [15:0] cell_word;
        logic        first_cell;
    } t_screen_cmd;

    class t_screen_tracker;
        logic [15:0] cells [ROWS*COLS];
        int          xfer_row;
        int          xfer_col;
        bit          xfer_closed;
        logic [3:0]  fg;
        logic [2:0]  bg;
        t_result     replies [$];
        int          mismatches;

        function new();
            foreach (cells[i]) cells[i] = 16'h0;
            xfer_row    = 0;
            xfer_col    = 0;
            xfer_closed = 1'b1;
            fg          = FG_RESET;
            bg          = BG_RESET;
            mismatches  = 0;
        endfunction

        function void set_colour(logic idx, logic [3:0] data);
            if (idx == CFG_FG) fg = data;
            else bg = data[2:0];
        endfunction

        function int waiting();
            return replies.size();
        endfunction

        // clip a region to the screen; 0 when it ends up empty
        function bit clip(t_screen_cmd c, output int r0, output int c0,
                          output int r1, output int c1);
            r0 = $signed(c.top_row);
            c0 = $signed(c.left_col);
            r1 = $signed(c.bottom_row);
            c1 = $signed(c.right_col);
            if (r0 < 0) r0 = 0;
            if (c0 < 0) c0 = 0;
            if (r1 >= ROWS) r1 = ROWS - 1;
            if (c1 >= COLS) c1 = COLS - 1;
            return r0 <= r1 && c0 <= c1;
        endfunction

        function void note_command(t_screen_cmd c);
            t_result    want;
            int         r, col, r0, c0, r1, c1, idx;
            bit         filled, go;
            logic [7:0] attr;
            want = '{status: STAT_IGNORED, value: 16'h0, last_cell: 1'b0};
            r    = $signed(c.top_row);
            col  = $signed(c.left_col);
            case (c.func)
                FN_PRINT, FN_READ: begin
                    if (r >= 0 && r < ROWS && col >= 0 && col < COLS) begin
                        idx = r * COLS + col;
                        if (c.func == FN_PRINT) begin
                            // background nibble survives, foreground from config
                            attr = {cells[idx][15:12], fg};
                            cells[idx] = {attr, c.char_code};
                        end else begin
                            want.value = cells[idx];
                        end
                        want.status = STAT_DONE;
                    end
                end
                FN_CLEAR, FN_SCROLL: begin
                    if (clip(c, r0, c0, r1, c1)) begin
                        for (r = r0; r <= r1; r++) begin
                            for (col = c0; col <= c1; col++) begin
                                idx = r * COLS + col;
                                if (c.func == FN_SCROLL && r < r1)
                                    cells[idx] = cells[idx + COLS];
                                else
                                    cells[idx] = {1'b0, bg, fg, BLANK_CHAR};
                            end
                        end
                        want.status = STAT_DONE;
                    end
                end
                FN_SAVE, FN_RESTORE: begin
                    filled = clip(c, r0, c0, r1, c1);
                    go     = 1'b0;
                    if (c.first_cell) begin
                        if (filled) begin
                            xfer_row    = r0;
                            xfer_col    = c0;
                            xfer_closed = 1'b0;
                            go          = 1'b1;
                        end else begin
                            xfer_closed = 1'b1;
                        end
                    end else if (xfer_closed) begin
                        want.status = STAT_PAST_END;
                    end else if (!filled) begin
                        xfer_closed = 1'b1;
                    end else if (xfer_row < r0 || xfer_row > r1 ||
                                 xfer_col < c0 || xfer_col > c1) begin
                        // region moved away from the cursor
                        want.status = STAT_PAST_END;
                        xfer_closed = 1'b1;
                    end else begin
                        go = 1'b1;
                    end
                    if (go) begin
                        idx = xfer_row * COLS + xfer_col;
                        if (idx >= ROWS * COLS) idx = 0;
                        if (c.func == FN_SAVE) want.value = cells[idx];
                        else cells[idx] = c.cell_word;
                        want.status = STAT_DONE;
                        xfer_col++;
                        if (xfer_col > c1) begin
                            xfer_col = c0;
                            xfer_row++;
                            if (xfer_row > r1) begin
                                xfer_closed    = 1'b1;
                                want.last_cell = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            replies.push_back(want);
        endfunction

        function void check_reply(logic [1:0] status, logic [15:0] value, logic last);
            t_result want;
            if (replies.size() == 0) begin
                $error("result word with nothing expected: status %0d, cell_value %h",
                       status, value);
                mismatches++;
                return;
            end
            want = replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                mismatches++;
            end
            if (value !== want.value) begin
                $error("cell_value: expected %h, got %h", want.value, value);
                mismatches++;
            end
            if (last !== want.last_cell) begin
                $error("last_cell: expected %0d, got %0d", want.last_cell, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_func;
    logic [7:0]  i_top_row;
    logic [7:0]  i_left_col;
    logic [7:0]  i_bottom_row;
    logic [7:0]  i_right_col;
    logic [7:0]  i_char_code;
    logic [15:0] i_cell_word;
    logic        i_first_cell;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_cell_value;
    logic        o_last_cell;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [3:0]  i_cfg_data;

    t_screen_tracker tracker;
    bit              hold_request = 1'b0;
    bit              no_idle      = 1'b0;
    int              cycle_count  = 0;

    text_screen_region_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_top_row    (i_top_row),
        .i_left_col   (i_left_col),
        .i_bottom_row (i_bottom_row),
        .i_right_col  (i_right_col),
        .i_char_code  (i_char_code),
        .i_cell_word  (i_cell_word),
        .i_first_cell (i_first_cell),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_cell_value (o_cell_value),
        .o_last_cell  (o_last_cell),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // positions lean towards the top-left corner so reads hit written cells
    function automatic int pick_row();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 1) : $urandom_range(0, 4);
    endfunction

    function automatic int pick_col();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, COLS - 1) : $urandom_range(0, 9);
    endfunction

    function automatic t_screen_cmd make_cmd(input int func, input int t, input int l,
                                             input int b, input int r, input int ch,
                                             input int word, input int first);
        t_screen_cmd c;
        c.func       = 3'(func);
        c.top_row    = 8'(t);
        c.left_col   = 8'(l);
        c.bottom_row = 8'(b);
        c.right_col  = 8'(r);
        c.char_code  = 8'(ch);
        c.cell_word  = 16'(word);
        c.first_cell = 1'(first);
        return c;
    endfunction

    // small region, sometimes hanging off an edge or empty
    function automatic void pick_region(output logic [7:0] t, output logic [7:0] l,
                                        output logic [7:0] b, output logic [7:0] rr);
        int r0, c0, h, w;
        h  = $urandom_range(0, 2);
        w  = $urandom_range(0, 4);
        r0 = pick_row();
        c0 = pick_col();
        if (r0 + h > ROWS - 1) r0 = ROWS - 1 - h;
        if (c0 + w > COLS - 1) c0 = COLS - 1 - w;
        t  = 8'(r0);
        b  = 8'(r0 + h);
        l  = 8'(c0);
        rr = 8'(c0 + w);
        case ($urandom_range(0, 9))
            0: begin t = 8'($urandom_range(128, 255)); b = 8'(h); end
            1: begin t = 8'(ROWS - 1 - h); b = 8'($urandom_range(ROWS - 1, 127)); end
            2: begin l = 8'($urandom_range(128, 255)); rr = 8'(w); end
            3: begin l = 8'(COLS - 1 - w); rr = 8'($urandom_range(COLS - 1, 127)); end
            4: b = 8'($urandom_range(128, 255));
            5: rr = (c0 > 0) ? 8'($urandom_range(0, c0 - 1)) : 8'($urandom_range(128, 255));
            default: ;
        endcase
    endfunction

    task automatic send_command(input t_screen_cmd c);
        int gap;
        i_in_valid   <= 1'b1;
        i_func       <= c.func;
        i_top_row    <= c.top_row;
        i_left_col   <= c.left_col;
        i_bottom_row <= c.bottom_row;
        i_right_col  <= c.right_col;
        i_char_code  <= c.char_code;
        i_cell_word  <= c.cell_word;
        i_first_cell <= c.first_cell;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_command(c);
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // both registers in one burst, valid held high across the two words
    task automatic write_colours(input logic [3:0] fg, input logic [3:0] bg);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FG;
        i_cfg_data  <= fg;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_colour(CFG_FG, fg);
        i_cfg_index <= CFG_BG;
        i_cfg_data  <= bg;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_colour(CFG_BG, bg);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.waiting() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input int target);
        t_screen_cmd c;
        logic [7:0]  t, l, b, rr;
        logic [2:0]  base;
        int          sent, steps;
        sent = 0;
        while (sent < target) begin
            case ($urandom_range(0, 39))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
                    // a whole save or restore pass with random content
                    pick_region(t, l, b, rr);
                    base = $urandom_range(0, 1) ? FN_SAVE : FN_RESTORE;
                    send_command(make_cmd(base, t, l, b, rr, $urandom, $urandom, 1));
                    sent++;
                    steps = 0;
                    while (!tracker.xfer_closed && steps < 30) begin
                        c = make_cmd(base, t, l, b, rr, $urandom, $urandom, 0);
                        case ($urandom_range(0, 29))
                            0: pick_region(c.top_row, c.left_col, c.bottom_row, c.right_col);
                            1: c.first_cell = 1'b1;
                            2, 3: c.func = (base == FN_SAVE) ? FN_RESTORE : FN_SAVE;
                            default: ;
                        endcase
                        send_command(c);
                        sent++;
                        steps++;
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        send_command(make_cmd(base, t, l, b, rr, $urandom, $urandom, 0));
                        sent++;
                    end
                end
                14, 15, 16, 17, 18, 19, 20, 21, 22, 23: begin
                    c = make_cmd(($urandom_range(0, 9) < 6) ? FN_PRINT : FN_READ,
                                 pick_row(), pick_col(), $urandom, $urandom, $urandom,
                                 $urandom, $urandom);
                    if ($urandom_range(0, 4) == 0) begin
                        c.top_row  = 8'($urandom);
                        c.left_col = 8'($urandom);
                    end
                    send_command(c);
                    sent++;
                end
                24, 25, 26, 27, 28, 29, 30, 31, 32, 33: begin
                    c = make_cmd(($urandom_range(0, 1) == 0) ? FN_CLEAR : FN_SCROLL,
                                 0, 0, 0, 0, $urandom, $urandom, $urandom);
                    pick_region(c.top_row, c.left_col, c.bottom_row, c.right_col);
                    send_command(c);
                    sent++;
                end
                34: begin
                    // whole screen: the slow walk
                    send_command(make_cmd(($urandom_range(0, 1) == 0) ? FN_CLEAR : FN_SCROLL,
                                          -$urandom_range(1, 128), -$urandom_range(1, 128),
                                          $urandom_range(ROWS - 1, 127),
                                          $urandom_range(COLS - 1, 127),
                                          $urandom, $urandom, $urandom));
                    sent++;
                end
                35, 36, 37: begin
                    c = make_cmd($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    if (c.func == FN_CLEAR || c.func == FN_SCROLL)
                        pick_region(c.top_row, c.left_col, c.bottom_row, c.right_col);
                    send_command(c);
                    if (c.func != FN_SPARE_A && c.func != FN_SPARE_B) sent++;
                end
                default: begin
                    // stray transfer word with arbitrary bounds
                    send_command(make_cmd(($urandom_range(0, 1) == 0) ? FN_SAVE : FN_RESTORE,
                                          $urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom));
                    sent++;
                end
            endcase
        end
    endtask

    initial begin : result_sink
        int stall_left, flow_left;
        stall_left  = 0;
        flow_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                tracker.check_reply(o_status, o_cell_value, o_last_cell);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
                flow_left    = 1;
            end
            if (stall_left == 0 && flow_left == 0) begin
                stall_left = no_idle ? 0 : idle_len();
                flow_left  = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                flow_left--;
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** text_screen_region_engine: FAILED **");
        $finish;
    end

    initial begin : stimulus
        tracker      = new();
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = FN_PRINT;
        i_top_row    = 8'h0;
        i_left_col   = 8'h0;
        i_bottom_row = 8'h0;
        i_right_col  = 8'h0;
        i_char_code  = 8'h0;
        i_cell_word  = 16'h0;
        i_first_cell = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_FG;
        i_cfg_data   = 4'h0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset colours
        send_command(make_cmd(FN_READ, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(FN_PRINT, 0, 0, 0, 0, 8'hff, 0, 0));
        send_command(make_cmd(FN_PRINT, ROWS - 1, COLS - 1, 0, 0, 8'h00, 0, 0));
        send_command(make_cmd(FN_PRINT, -1, 0, 0, 0, 8'h55, 0, 0));
        send_command(make_cmd(FN_PRINT, ROWS, COLS, 0, 0, 8'haa, 0, 0));
        send_command(make_cmd(FN_READ, 127, -128, 0, 0, 0, 0, 0));
        send_command(make_cmd(FN_READ, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(FN_CLEAR, -128, -5, 1, 3, 0, 0, 0));
        send_command(make_cmd(FN_SCROLL, 0, 0, 2, 3, 0, 0, 0));
        send_command(make_cmd(FN_CLEAR, 5, 0, 4, 3, 0, 0, 0));
        send_command(make_cmd(FN_SCROLL, 0, 5, 3, 4, 0, 0, 0));
        // restore off the bottom-right corner, then one word too many
        send_command(make_cmd(FN_RESTORE, ROWS - 2, COLS - 2, 127, 127, 0, 16'hffff, 1));
        send_command(make_cmd(FN_RESTORE, ROWS - 2, COLS - 2, 127, 127, 0, 16'h8000, 0));
        send_command(make_cmd(FN_RESTORE, ROWS - 2, COLS - 2, 127, 127, 0, 16'h1234, 0));
        send_command(make_cmd(FN_RESTORE, ROWS - 2, COLS - 2, 127, 127, 0, 16'h00ff, 0));
        send_command(make_cmd(FN_RESTORE, ROWS - 2, COLS - 2, 127, 127, 0, 16'h5a5a, 0));
        send_command(make_cmd(FN_SAVE, ROWS - 2, COLS - 2, 127, 127, 0, 0, 1));
        send_command(make_cmd(FN_SAVE, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(FN_SAVE, 3, 0, -1, 5, 0, 0, 1));
        send_command(make_cmd(FN_SAVE, 3, 0, -1, 5, 0, 0, 0));
        send_command(make_cmd(FN_SPARE_A, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(FN_SPARE_B, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(FN_PRINT, ROWS - 2, COLS - 2, 0, 0, 8'h41, 0, 0));
        send_command(make_cmd(FN_SCROLL, -128, -128, 127, 127, 0, 0, 0));
        send_command(make_cmd(FN_READ, ROWS - 1, COLS - 1, 0, 0, 0, 0, 0));
        drain();

        write_colours(4'h0, 4'h0);
        random_phase(75);
        drain();

        // long hold on the result side while words keep coming
        write_colours(4'hf, 4'hf);
        hold_request = 1'b1;
        random_phase(75);
        drain();

        write_colours(4'($urandom), {1'b1, 3'($urandom)});
        no_idle = 1'b1;
        random_phase(40);
        no_idle = 1'b0;
        random_phase(35);
        drain();

        write_colours(4'($urandom), 4'($urandom));
        random_phase(75);
        drain();

        if (tracker.mismatches == 0 && tracker.waiting() == 0)
            $display("** text_screen_region_engine: PASSED **");
        else
            $display("** text_screen_region_engine: FAILED **");
        $finish;
    end
endmodule
